[rtl/lirs_pkg.sv]
// ============================================================================
// lirs_pkg: shared constants and types for the linear interpolation resampler
// Holds field widths, register indexes, reset values and the back-end states.
// ============================================================================
package lirs_pkg;

    // Default widths of samples and stream counters.
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int COUNT_WIDTH_DEF  = 32;

    // Configuration register widths.
    localparam int CHAN_W      = 2;
    localparam int RATE_IN_W   = 18;
    localparam int RATE_OUT_W  = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 18;

    // Width of remainder plus input rate, the dividend of a position step.
    localparam int STEP_W = 19;

    // Result cap per request, depth of the pending queue and of the job queue.
    localparam int MAX_RESULTS     = 16;
    localparam int PEND_DEPTH      = 4;
    localparam int JOB_QUEUE_DEPTH = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_RATE       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_RATE      = 2'd2;

    // Configuration reset values.
    localparam logic [CHAN_W-1:0]     CHAN_RESET     = 2'd2;
    localparam logic [CHAN_W-1:0]     CHAN_STEREO    = 2'd2;
    localparam logic [RATE_IN_W-1:0]  IN_RATE_RESET  = 18'd44100;
    localparam logic [RATE_OUT_W-1:0] OUT_RATE_RESET = 16'd48000;

    // Back-end sequencer states.
    typedef enum logic [9:0] {
        ST_IDLE   = 10'b00_0000_0001,
        ST_FOLD   = 10'b00_0000_0010,
        ST_DRAIN  = 10'b00_0000_0100,
        ST_SPAN   = 10'b00_0000_1000,
        ST_CHECK  = 10'b00_0001_0000,
        ST_MUL    = 10'b00_0010_0000,
        ST_LOAD   = 10'b00_0100_0000,
        ST_WAIT   = 10'b00_1000_0000,
        ST_DECIDE = 10'b01_0000_0000,
        ST_FINISH = 10'b10_0000_0000
    } t_back_state;

endpackage

[rtl/lirs_if.sv]
// ============================================================================
// lirs_if: request channels of the resampler
// An input frame channel and a result channel, each with valid and ready.
// ============================================================================

// Input frame channel.
interface lirs_in_if import lirs_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
    logic                    valid;
    logic                    ready;
    logic [SAMPLE_WIDTH-1:0] left_sample;
    logic [SAMPLE_WIDTH-1:0] right_sample;
    logic                    is_last;

    modport source (output valid, output left_sample, output right_sample,
                    output is_last, input ready);
    modport sink   (input valid, input left_sample, input right_sample,
                    input is_last, output ready);
endinterface

// Result channel.
interface lirs_out_if import lirs_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
    logic                    valid;
    logic                    ready;
    logic [SAMPLE_WIDTH-1:0] left_out;
    logic [SAMPLE_WIDTH-1:0] right_out;
    logic                    end_of_run;

    modport source (output valid, output left_out, output right_out,
                    output end_of_run, input ready);
    modport sink   (input valid, input left_out, input right_out,
                    input end_of_run, output ready);
endinterface

[rtl/lirs_front.sv]
// ============================================================================
// lirs_front: input side of the resampler
// Accepts frame requests, zeroes the right lane in mono and queues the jobs.
// ============================================================================
module lirs_front import lirs_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_mono,
    lirs_in_if.sink                 i_src,
    output logic                    o_job_valid,
    input  logic                    i_job_pop,
    output logic [SAMPLE_WIDTH-1:0] o_job_left,
    output logic [SAMPLE_WIDTH-1:0] o_job_right,
    output logic                    o_job_last
);

    localparam int PTR_W = $clog2(JOB_QUEUE_DEPTH);
    localparam int CNT_W = $clog2(JOB_QUEUE_DEPTH + 1);

    logic [SAMPLE_WIDTH-1:0] r_q_left  [JOB_QUEUE_DEPTH];
    logic [SAMPLE_WIDTH-1:0] r_q_right [JOB_QUEUE_DEPTH];
    logic                    r_q_last  [JOB_QUEUE_DEPTH];
    logic [PTR_W-1:0]        r_wr;
    logic [PTR_W-1:0]        r_rd;
    logic [CNT_W-1:0]        r_cnt;
    logic                    w_push;
    logic                    w_pop;

    // Handshake and queue status.
    assign i_src.ready = (r_cnt != CNT_W'(JOB_QUEUE_DEPTH));
    assign w_push      = i_src.valid && i_src.ready;
    assign o_job_valid = (r_cnt != '0);
    assign w_pop       = i_job_pop && o_job_valid;

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Classified frame storage; the right lane is forced to zero in mono.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q_left[r_wr]  <= i_src.left_sample;
            r_q_right[r_wr] <= i_mono ? '0 : i_src.right_sample;
            r_q_last[r_wr]  <= i_src.is_last;
        end
    end

    assign o_job_left  = r_q_left[r_rd];
    assign o_job_right = r_q_right[r_rd];
    assign o_job_last  = r_q_last[r_rd];

endmodule

[rtl/lirs_div.sv]
// ============================================================================
// lirs_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle; the caller supplies a
// starting partial remainder below the divisor and the low dividend bits.
// ============================================================================
module lirs_div import lirs_pkg::*; #(
    parameter int Q_W   = STEP_W,
    parameter int DVS_W = RATE_OUT_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVS_W-1:0] i_rem_init,
    input  logic [Q_W-1:0]   i_low,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_busy,
    output logic [Q_W-1:0]   o_quot,
    output logic [DVS_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(Q_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic [DVS_W-1:0] r_rem;
    logic [Q_W-1:0]   r_quot;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W:0]   w_trial;
    logic [DVS_W:0]   w_diff;
    logic             w_ge;

    // One trial subtraction per cycle.
    assign w_trial = {r_rem, r_quot[Q_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});
    assign w_diff  = w_trial - {1'b0, r_dvs};

    // Step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(Q_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Dividend bits shift out at the top while quotient bits shift in below.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_rem_init;
            r_quot <= i_low;
            r_dvs  <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem  <= w_ge ? w_diff[DVS_W-1:0] : w_trial[DVS_W-1:0];
            r_quot <= {r_quot[Q_W-2:0], w_ge};
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

[rtl/lirs_back.sv]
// ============================================================================
// lirs_back: output side of the resampler
// Tracks the output position, interpolates both lanes, holds outputs that
// wait for later frames and delivers results through a two-deep output stage.
// ============================================================================
module lirs_back import lirs_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [RATE_IN_W-1:0]    i_in_rate,
    input  logic [RATE_OUT_W-1:0]   i_out_rate,
    input  logic                    i_job_valid,
    output logic                    o_job_pop,
    input  logic [SAMPLE_WIDTH-1:0] i_job_left,
    input  logic [SAMPLE_WIDTH-1:0] i_job_right,
    input  logic                    i_job_last,
    lirs_out_if.source              o_res
);

    localparam int SW      = SAMPLE_WIDTH;
    localparam int CW      = COUNT_WIDTH;
    localparam int NW      = ((CW > STEP_W) ? CW : STEP_W) + 1;
    localparam int PW      = SW + RATE_OUT_W + 1;
    localparam int DW      = SW + RATE_OUT_W;
    localparam int NRES_W  = $clog2(MAX_RESULTS + 1);
    localparam int PCNT_W  = $clog2(PEND_DEPTH + 1);
    localparam int PIDX_W  = $clog2(PEND_DEPTH);

    t_back_state r_state;
    t_back_state n_state;

    // Stream state.
    logic [SW-1:0]         r_cur_l;
    logic [SW-1:0]         r_cur_r;
    logic                  r_last;
    logic                  r_span;
    logic [SW-1:0]         r_prev_l;
    logic [SW-1:0]         r_prev_r;
    logic                  r_have_prev;
    logic [CW-1:0]         r_frames;
    logic [CW-1:0]         r_pos;
    logic [RATE_OUT_W-1:0] r_rem;

    // Pending outputs that wait for more frames.
    logic [SW-1:0]         r_pend_l    [PEND_DEPTH];
    logic [SW-1:0]         r_pend_r    [PEND_DEPTH];
    logic [NW-1:0]         r_pend_need [PEND_DEPTH];
    logic [PCNT_W-1:0]     r_pend_cnt;

    // Interpolation products and signs.
    logic signed [PW-1:0]  r_pa_l;
    logic signed [PW-1:0]  r_pb_l;
    logic signed [PW-1:0]  r_pa_r;
    logic signed [PW-1:0]  r_pb_r;
    logic                  r_neg_l;
    logic                  r_neg_r;

    // Held result and output register.
    logic                  r_hold_v;
    logic [SW-1:0]         r_hold_l;
    logic [SW-1:0]         r_hold_r;
    logic                  r_out_v;
    logic [SW-1:0]         r_out_l;
    logic [SW-1:0]         r_out_r;
    logic                  r_out_eor;
    logic [NRES_W-1:0]     r_nres;

    // Combinational signals.
    logic                  w_rate_zero;
    logic [NW-1:0]         w_frames;
    logic [CW-1:0]         w_tgt;
    logic [SW-1:0]         w_a_l;
    logic [SW-1:0]         w_a_r;
    logic [RATE_OUT_W-1:0] w_ormr;
    logic signed [PW-1:0]  w_num_l;
    logic signed [PW-1:0]  w_num_r;
    logic [PW-1:0]         w_abs_l;
    logic [PW-1:0]         w_abs_r;
    logic [NW-1:0]         w_pos_sum;
    logic [NW-1:0]         w_need;
    logic [SW-1:0]         w_val_l;
    logic [SW-1:0]         w_val_r;
    logic                  w_drain;
    logic                  w_adv_start;
    logic [STEP_W-1:0]     w_adv_low;
    logic                  w_adv_busy;
    logic [STEP_W-1:0]     w_adv_quot;
    logic [RATE_OUT_W-1:0] w_adv_rem;
    logic                  w_int_start;
    logic                  w_il_busy;
    logic                  w_ir_busy;
    logic [SW-1:0]         w_il_quot;
    logic [SW-1:0]         w_ir_quot;
    logic [RATE_OUT_W-1:0] w_il_rem;
    logic [RATE_OUT_W-1:0] w_ir_rem;
    logic                  w_emit_req;
    logic [SW-1:0]         w_emit_l;
    logic [SW-1:0]         w_emit_r;
    logic                  w_emit_go;
    logic                  w_emit_take;
    logic                  w_push;
    logic                  w_pop;
    logic                  w_out_free;
    logic                  w_fin_go;
    logic                  w_out_load;
    logic                  w_capped;

    // Frame pair and position arithmetic.
    assign w_rate_zero = (i_in_rate == '0) || (i_out_rate == '0);
    assign w_frames    = NW'(r_frames) + 1'b1;
    assign w_tgt       = r_span ? r_frames : r_frames - 1'b1;
    assign w_a_l       = r_span ? r_cur_l : r_prev_l;
    assign w_a_r       = r_span ? r_cur_r : r_prev_r;
    assign w_ormr      = i_out_rate - r_rem;
    assign w_pos_sum   = NW'(r_pos) + NW'(w_adv_quot);
    assign w_need      = w_pos_sum + NW'(w_adv_rem != '0);
    assign w_drain     = (r_pend_cnt != '0) && (r_pend_need[0] <= w_frames);

    // Numerator a*(out-r) + b*r and its magnitude for the lane dividers.
    assign w_num_l = r_pa_l + r_pb_l;
    assign w_num_r = r_pa_r + r_pb_r;
    assign w_abs_l = w_num_l[PW-1] ? -w_num_l : w_num_l;
    assign w_abs_r = w_num_r[PW-1] ? -w_num_r : w_num_r;

    // Quotients truncate toward zero: restore the sign of the numerator.
    assign w_val_l = r_neg_l ? (~w_il_quot + 1'b1) : w_il_quot;
    assign w_val_r = r_neg_r ? (~w_ir_quot + 1'b1) : w_ir_quot;

    // Shared divider for folding and stepping the position by in/out.
    lirs_div #(
        .Q_W   (STEP_W),
        .DVS_W (RATE_OUT_W)
    ) u_adv_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_adv_start),
        .i_rem_init ('0),
        .i_low      (w_adv_low),
        .i_divisor  (i_out_rate),
        .o_busy     (w_adv_busy),
        .o_quot     (w_adv_quot),
        .o_rem      (w_adv_rem)
    );

    // Lane dividers for the interpolated values.
    lirs_div #(
        .Q_W   (SW),
        .DVS_W (RATE_OUT_W)
    ) u_left_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_int_start),
        .i_rem_init (w_abs_l[DW-1:SW]),
        .i_low      (w_abs_l[SW-1:0]),
        .i_divisor  (i_out_rate),
        .o_busy     (w_il_busy),
        .o_quot     (w_il_quot),
        .o_rem      (w_il_rem)
    );

    lirs_div #(
        .Q_W   (SW),
        .DVS_W (RATE_OUT_W)
    ) u_right_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_int_start),
        .i_rem_init (w_abs_r[DW-1:SW]),
        .i_low      (w_abs_r[SW-1:0]),
        .i_divisor  (i_out_rate),
        .o_busy     (w_ir_busy),
        .o_quot     (w_ir_quot),
        .o_rem      (w_ir_rem)
    );

    // Emission: a new result waits in the hold register so that the last one
    // of a request can be marked; the older one moves to the output register.
    assign w_out_free  = !r_out_v || o_res.ready;
    assign w_capped    = (r_nres == NRES_W'(MAX_RESULTS));
    assign w_emit_go   = w_capped || !r_hold_v || w_out_free;
    assign w_emit_take = w_emit_req && w_emit_go && !w_capped;
    assign w_fin_go    = (r_state == ST_FINISH) && (!r_hold_v || w_out_free);
    assign w_out_load  = r_hold_v && (w_emit_take || w_fin_go);

    // Sequencer next state and unit starts.
    always_comb begin
        n_state     = r_state;
        o_job_pop   = 1'b0;
        w_adv_start = 1'b0;
        w_adv_low   = STEP_W'(r_rem);
        w_int_start = 1'b0;
        w_emit_req  = 1'b0;
        w_emit_l    = r_pend_l[0];
        w_emit_r    = r_pend_r[0];
        w_push      = 1'b0;
        w_pop       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    if (w_rate_zero) begin
                        n_state = ST_FINISH;
                    end else begin
                        w_adv_start = 1'b1;
                        n_state     = ST_FOLD;
                    end
                end
            end
            ST_FOLD: begin
                if (!w_adv_busy) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_drain) begin
                    w_emit_req = 1'b1;
                    w_pop      = w_emit_go;
                end else if ((r_have_prev && r_frames != '0) || r_last) begin
                    n_state = ST_SPAN;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_SPAN: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (r_pos == w_tgt) begin
                    w_adv_start = 1'b1;
                    w_adv_low   = STEP_W'(r_rem) + STEP_W'(i_in_rate);
                    n_state     = ST_MUL;
                end else if (!r_span && r_last) begin
                    n_state = ST_SPAN;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_MUL: begin
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                w_int_start = 1'b1;
                n_state     = ST_WAIT;
            end
            ST_WAIT: begin
                if (!w_adv_busy && !w_il_busy && !w_ir_busy) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (w_need <= w_frames) begin
                    w_emit_req = 1'b1;
                    w_emit_l   = w_val_l;
                    w_emit_r   = w_val_r;
                    if (w_emit_go) begin
                        n_state = ST_CHECK;
                    end
                end else begin
                    w_push  = !r_last && (r_pend_cnt < PCNT_W'(PEND_DEPTH));
                    n_state = ST_CHECK;
                end
            end
            ST_FINISH: begin
                if (w_fin_go) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Sequencer and stream state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cur_l     <= '0;
            r_cur_r     <= '0;
            r_last      <= 1'b0;
            r_span      <= 1'b0;
            r_prev_l    <= '0;
            r_prev_r    <= '0;
            r_have_prev <= 1'b0;
            r_frames    <= '0;
            r_pos       <= '0;
            r_rem       <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_IDLE: begin
                    if (i_job_valid) begin
                        r_cur_l <= i_job_left;
                        r_cur_r <= i_job_right;
                        r_last  <= i_job_last;
                    end
                end
                ST_FOLD: begin
                    // Fold a remainder left over from a larger output rate.
                    if (!w_adv_busy) begin
                        r_pos <= w_pos_sum[CW-1:0];
                        r_rem <= w_adv_rem;
                    end
                end
                ST_DRAIN: begin
                    if (!w_drain) begin
                        r_span <= !(r_have_prev && r_frames != '0);
                    end
                end
                ST_SPAN: begin
                    // A lagging position jumps to the older frame of the pair.
                    if (r_pos < w_tgt) begin
                        r_pos <= w_tgt;
                        r_rem <= '0;
                    end
                end
                ST_CHECK: begin
                    if (r_pos != w_tgt && !r_span && r_last) begin
                        r_span <= 1'b1;
                    end
                end
                ST_DECIDE: begin
                    if (n_state == ST_CHECK) begin
                        r_pos <= w_pos_sum[CW-1:0];
                        r_rem <= w_adv_rem;
                    end
                end
                ST_FINISH: begin
                    if (w_fin_go) begin
                        if (r_last) begin
                            r_prev_l    <= '0;
                            r_prev_r    <= '0;
                            r_have_prev <= 1'b0;
                            r_frames    <= '0;
                            r_pos       <= '0;
                            r_rem       <= '0;
                        end else begin
                            r_prev_l    <= r_cur_l;
                            r_prev_r    <= r_cur_r;
                            r_have_prev <= 1'b1;
                            r_frames    <= r_frames + 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Products of the frame pair with the position weights.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_MUL) begin
            r_pa_l <= $signed(w_a_l) * $signed({1'b0, w_ormr});
            r_pb_l <= $signed(r_cur_l) * $signed({1'b0, r_rem});
            r_pa_r <= $signed(w_a_r) * $signed({1'b0, w_ormr});
            r_pb_r <= $signed(r_cur_r) * $signed({1'b0, r_rem});
        end
        if (w_int_start) begin
            r_neg_l <= w_num_l[PW-1];
            r_neg_r <= w_num_r[PW-1];
        end
    end

    // Pending queue: pushed at the tail, drained from the head.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_cnt <= '0;
        end else if (w_fin_go && r_last) begin
            r_pend_cnt <= '0;
        end else if (w_pop) begin
            r_pend_cnt <= r_pend_cnt - 1'b1;
        end else if (w_push) begin
            r_pend_cnt <= r_pend_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            for (int i = 0; i < PEND_DEPTH - 1; i++) begin
                r_pend_l[i]    <= r_pend_l[i+1];
                r_pend_r[i]    <= r_pend_r[i+1];
                r_pend_need[i] <= r_pend_need[i+1];
            end
        end else if (w_push) begin
            r_pend_l[r_pend_cnt[PIDX_W-1:0]]    <= w_val_l;
            r_pend_r[r_pend_cnt[PIDX_W-1:0]]    <= w_val_r;
            r_pend_need[r_pend_cnt[PIDX_W-1:0]] <= w_need;
        end
    end

    // Hold and output stage control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_hold_v <= 1'b0;
            r_nres   <= '0;
        end else begin
            if (w_out_load) begin
                r_out_v <= 1'b1;
            end else if (o_res.ready) begin
                r_out_v <= 1'b0;
            end
            if (w_emit_take) begin
                r_hold_v <= 1'b1;
                r_nres   <= r_nres + 1'b1;
            end else if (w_fin_go) begin
                r_hold_v <= 1'b0;
                r_nres   <= '0;
            end
        end
    end

    // Hold and output stage data; the request's last result carries the mark.
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_l   <= r_hold_l;
            r_out_r   <= r_hold_r;
            r_out_eor <= w_fin_go;
        end
        if (w_emit_take) begin
            r_hold_l <= w_emit_l;
            r_hold_r <= w_emit_r;
        end
    end

    assign o_res.valid      = r_out_v;
    assign o_res.left_out   = r_out_l;
    assign o_res.right_out  = r_out_r;
    assign o_res.end_of_run = r_out_eor;

endmodule

[rtl/linear_interp_resampler.sv]
// ============================================================================
// linear_interp_resampler: the back end takes one frame request at a time;
// it drains ready pending outputs, then forms new ones, and the last frame
// adds its tail. The 19-step position divider, one quotient bit per cycle,
// sets the output time.
// Synchronous active-low reset clears stream state and restores config values.
// ============================================================================
module linear_interp_resampler import lirs_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    lirs_in_if.sink               i_src,
    lirs_out_if.source            o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [CHAN_W-1:0]       r_chan;
    logic [RATE_IN_W-1:0]    r_in_rate;
    logic [RATE_OUT_W-1:0]   r_out_rate;
    logic                    w_job_valid;
    logic                    w_job_pop;
    logic [SAMPLE_WIDTH-1:0] w_job_left;
    logic [SAMPLE_WIDTH-1:0] w_job_right;
    logic                    w_job_last;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan     <= CHAN_RESET;
            r_in_rate  <= IN_RATE_RESET;
            r_out_rate <= OUT_RATE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CHANNEL_COUNT: r_chan     <= i_cfg_data[CHAN_W-1:0];
                CFG_IN_RATE:       r_in_rate  <= i_cfg_data[RATE_IN_W-1:0];
                CFG_OUT_RATE:      r_out_rate <= i_cfg_data[RATE_OUT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Front: frame requests into the job queue.
    lirs_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mono      (r_chan != CHAN_STEREO),
        .i_src       (i_src),
        .o_job_valid (w_job_valid),
        .i_job_pop   (w_job_pop),
        .o_job_left  (w_job_left),
        .o_job_right (w_job_right),
        .o_job_last  (w_job_last)
    );

    // Back: position tracking, interpolation and result delivery.
    lirs_back #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_rate   (r_in_rate),
        .i_out_rate  (r_out_rate),
        .i_job_valid (w_job_valid),
        .o_job_pop   (w_job_pop),
        .i_job_left  (w_job_left),
        .i_job_right (w_job_right),
        .i_job_last  (w_job_last),
        .o_res       (o_res)
    );

endmodule

[rtl/lirs_checker.sv]
// ============================================================================
// lirs_checker: port-level checks for the resampler
// Watches the result channel against reset and accepted frame requests.
// ============================================================================
module lirs_checker import lirs_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_src_valid,
    input logic                    i_src_ready,
    input logic                    i_res_valid,
    input logic                    i_res_ready,
    input logic [SAMPLE_WIDTH-1:0] i_res_left,
    input logic [SAMPLE_WIDTH-1:0] i_res_right,
    input logic                    i_res_eor
);

    logic r_seen;

    // Remembers that a frame request was taken since reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (i_src_valid && i_src_ready) begin
            r_seen <= 1'b1;
        end
    end

    // A stalled result stays offered.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its payload.
    a_res_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=>
            $stable(i_res_left) && $stable(i_res_right) && $stable(i_res_eor))
        else $error("result payload changed while stalled");

    // Reset empties the output stage.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result offered right after reset");

    // No result appears before any frame was taken.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> r_seen)
        else $error("result offered without any frame request");

endmodule

bind linear_interp_resampler lirs_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_lirs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_src_valid (i_src.valid),
    .i_src_ready (i_src.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_left  (o_res.left_out),
    .i_res_right (o_res.right_out),
    .i_res_eor   (o_res.end_of_run)
);
